FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising clk edge, reset included.
`define AST_CLK_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mi3_pkg.sv
// Types and constants of the 3x3 matrix inverse block.
// No dependencies; used by matrix3_inverse and mi3_chk.
package mi3_pkg;
  localparam int EW = 32;  // entry width, Q16.16
  localparam int CW = 64;  // cofactor width
  localparam int DW = 98;  // determinant and remainder width
  localparam int QW = 32;  // quotient width
  localparam int NE = 9;   // entries per matrix

  localparam logic [QW-1:0] POS_LIM = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] NEG_LIM = 32'h8000_0000;

  typedef struct packed {
    logic signed [EW-1:0] e00;
    logic signed [EW-1:0] e01;
    logic signed [EW-1:0] e02;
    logic signed [EW-1:0] e10;
    logic signed [EW-1:0] e11;
    logic signed [EW-1:0] e12;
    logic signed [EW-1:0] e20;
    logic signed [EW-1:0] e21;
    logic signed [EW-1:0] e22;
  } mi3_in_t;

  typedef struct packed {
    logic signed [EW-1:0] r00;
    logic signed [EW-1:0] r01;
    logic signed [EW-1:0] r02;
    logic signed [EW-1:0] r10;
    logic signed [EW-1:0] r11;
    logic signed [EW-1:0] r12;
    logic signed [EW-1:0] r20;
    logic signed [EW-1:0] r21;
    logic signed [EW-1:0] r22;
    logic                 singular;
    logic                 overflow;
  } mi3_out_t;
endpackage

FILE: rtl/matrix3_inverse.sv
// 3x3 matrix inverse in signed Q16.16 by the adjugate method, fully pipelined.
// Depends on mi3_pkg.
//
// Takes one matrix per cycle while in_stall is low. The nine entries are
// divided by the determinant in a restoring divide that makes one quotient
// bit per stage over 32 stages; ahead of it sit the minor-product multiply,
// the cofactor subtract, the stages that build the determinant and two that
// prepare sign, magnitude and range check. While a finished result is
// stalled, every stage holds and in_stall is raised.
// Quotients truncate toward zero; out-of-range entries saturate and set
// overflow; a zero determinant gives all-zero entries with singular set.
module matrix3_inverse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mi3_pkg::mi3_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mi3_pkg::mi3_out_t out_data
);
  import mi3_pkg::*;

  localparam int NDIV = QW;

  logic adv;
  logic out_valid_r;
  mi3_out_t out_data_r, out_nxt;

  logic signed [EW-1:0] a [NE];

  logic signed [2*EW-1:0] pp_r [NE];
  logic signed [2*EW-1:0] pq_r [NE];
  logic signed [EW-1:0]   row1_r [3];
  logic signed [EW-1:0]   row2_r [3];
  logic [CW-1:0]          cof2_r [NE];
  logic [CW-1:0]          cof3_r [NE];
  logic [CW-1:0]          cof4_r [NE];
  logic [CW-1:0]          cof5_r [NE];
  logic [CW-1:0]          cof6_r [NE];
  logic signed [2*EW-1:0] ph_r [3];
  logic signed [2*EW:0]   pl_r [3];
  logic signed [DW-1:0]   t_r [3];
  logic signed [DW-1:0]   det_r;
  logic [DW-1:0]          dabs6_r;
  logic                   dneg6_r;
  logic                   sing6_r;
  logic                   v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic [DW-1:0] rem_r  [NDIV+1][NE];
  logic [QW-1:0] quo_r  [NDIV+1][NE];
  logic [NE-1:0] neg_r  [NDIV+1];
  logic [NE-1:0] big_r  [NDIV+1];
  logic [DW-1:0] dabs_r [NDIV+1];
  logic          sing_r [NDIV+1];
  logic          vd_r   [NDIV+1];

  logic [QW-1:0] res_w [NE];
  logic [NE-1:0] sat_w;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign a[0] = in_data.e00;
  assign a[1] = in_data.e01;
  assign a[2] = in_data.e02;
  assign a[3] = in_data.e10;
  assign a[4] = in_data.e11;
  assign a[5] = in_data.e12;
  assign a[6] = in_data.e20;
  assign a[7] = in_data.e21;
  assign a[8] = in_data.e22;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      for (int k = 0; k <= NDIV; k++) vd_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      vd_r[0] <= v6_r;
      for (int k = 0; k < NDIV; k++) vd_r[k+1] <= vd_r[k];
      out_valid_r <= vd_r[NDIV];
    end
  end

  // stage 1: 2x2 minor products; stage 2: signed cofactors (64-bit wrap)
  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam int I1 = (gi + 1) % 3;
      localparam int I2 = (gi + 2) % 3;
      localparam int J1 = (gj + 1) % 3;
      localparam int J2 = (gj + 2) % 3;
      always_ff @(posedge clk) begin
        if (adv) begin
          pp_r[gi*3+gj]   <= a[I1*3+J1] * a[I2*3+J2];
          pq_r[gi*3+gj]   <= a[I1*3+J2] * a[I2*3+J1];
          cof2_r[gi*3+gj] <= pp_r[gi*3+gj] - pq_r[gi*3+gj];
        end
      end
    end
  end

  // stages 3..6: determinant from the first row, then sign and magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        row1_r[j] <= a[j];
        row2_r[j] <= row1_r[j];
        ph_r[j]   <= $signed(cof2_r[j][CW-1:EW]) * row2_r[j];
        pl_r[j]   <= $signed({1'b0, cof2_r[j][EW-1:0]}) * row2_r[j];
        t_r[j]    <= {{(DW-3*EW){ph_r[j][2*EW-1]}}, ph_r[j], {EW{1'b0}}}
                   + {{(DW-2*EW-1){pl_r[j][2*EW]}}, pl_r[j]};
      end
      cof3_r  <= cof2_r;
      cof4_r  <= cof3_r;
      cof5_r  <= cof4_r;
      cof6_r  <= cof5_r;
      det_r   <= t_r[0] + t_r[1] + t_r[2];
      dneg6_r <= det_r[DW-1];
      dabs6_r <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      sing6_r <= (det_r == '0);
    end
  end

  // stage 7: transpose, cofactor magnitude, range check, divider load
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int x = 0; x < 3; x++) begin
        for (int y = 0; y < 3; y++) begin
          rem_r[0][x*3+y] <= {{(DW-CW){1'b0}},
                              (cof6_r[y*3+x][CW-1] ? (~cof6_r[y*3+x] + 1'b1)
                                                   : cof6_r[y*3+x])};
          big_r[0][x*3+y] <= {{(DW-CW){1'b0}},
                              (cof6_r[y*3+x][CW-1] ? (~cof6_r[y*3+x] + 1'b1)
                                                   : cof6_r[y*3+x])} >= dabs6_r;
          neg_r[0][x*3+y] <= cof6_r[y*3+x][CW-1] ^ dneg6_r;
          quo_r[0][x*3+y] <= '0;
        end
      end
      dabs_r[0] <= dabs6_r;
      sing_r[0] <= sing6_r;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar gk = 0; gk < NDIV; gk++) begin : g_div
    logic [DW-1:0] sh_w [NE];
    logic [NE-1:0] ge_w;
    always_comb begin
      for (int n = 0; n < NE; n++) begin
        sh_w[n] = {rem_r[gk][n][DW-2:0], 1'b0};
        ge_w[n] = sh_w[n] >= dabs_r[gk];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int n = 0; n < NE; n++) begin
          rem_r[gk+1][n] <= ge_w[n] ? sh_w[n] - dabs_r[gk] : sh_w[n];
          quo_r[gk+1][n] <= {quo_r[gk][n][QW-2:0], ge_w[n]};
        end
        neg_r[gk+1]  <= neg_r[gk];
        big_r[gk+1]  <= big_r[gk];
        dabs_r[gk+1] <= dabs_r[gk];
        sing_r[gk+1] <= sing_r[gk];
      end
    end
  end

  // saturation, sign and singular handling
  always_comb begin
    for (int n = 0; n < NE; n++) begin
      sat_w[n] = big_r[NDIV][n] ||
                 (quo_r[NDIV][n] > (neg_r[NDIV][n] ? NEG_LIM : POS_LIM));
      res_w[n] = sat_w[n] ? (neg_r[NDIV][n] ? NEG_LIM : POS_LIM) : quo_r[NDIV][n];
      if (neg_r[NDIV][n]) res_w[n] = ~res_w[n] + 1'b1;
      if (sing_r[NDIV]) res_w[n] = '0;
    end
    out_nxt.r00      = res_w[0];
    out_nxt.r01      = res_w[1];
    out_nxt.r02      = res_w[2];
    out_nxt.r10      = res_w[3];
    out_nxt.r11      = res_w[4];
    out_nxt.r12      = res_w[5];
    out_nxt.r20      = res_w[6];
    out_nxt.r21      = res_w[7];
    out_nxt.r22      = res_w[8];
    out_nxt.singular = sing_r[NDIV];
    out_nxt.overflow = !sing_r[NDIV] && (|sat_w);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end
endmodule

FILE: rtl/mi3_chk.sv
// Port checker for matrix3_inverse, bound to every instance of it.
// Depends on mi3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mi3_props (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input mi3_pkg::mi3_out_t out_data
);
  import mi3_pkg::*;

  logic [NE*EW-1:0] ent_w;
  assign ent_w = out_data[NE*EW+1:2];

  // stalled request holds
  `AST_CLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)), "out request changed while stalled")
  // input only back-pressured by a stalled result
  `AST_CLK(a_in_stall, in_stall |-> (out_valid && out_stall), "in_stall without stalled result")
  // singular result is all zero and never flags overflow
  `AST_CLK(a_singular, (out_valid && out_data.singular) |-> ((ent_w == '0) && !out_data.overflow), "singular result not clean")
  // reset clears the result channel
  `AST_CLK_ANY(a_rst_idle, !rst_n |=> !out_valid, "out_valid set after reset")
endmodule

bind matrix3_inverse mi3_props u_mi3_props (.*);
